// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- rtl/cptrb_pkg.sv -----
// Package for the rectangle border clamp: widths, register indexes and types.
// No dependencies.
`default_nettype none

package cptrb_pkg;

    // Coordinate width and binary point position.
    localparam int CW = 32;
    localparam int FRAC_BITS = 16;

    // Width of the wide products and the numbers derived from them.
    localparam int PW = 2 * CW + 1;

    // Divider: quotient bits per pipeline stage and stage count.
    localparam int DIV_BITS = 2;
    localparam int DIV_STAGES = CW / DIV_BITS;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_X = 2'd0;
    localparam logic [1:0] REG_MIN_Y = 2'd1;
    localparam logic [1:0] REG_MAX_X = 2'd2;
    localparam logic [1:0] REG_MAX_Y = 2'd3;

    // Reset values: -1.0 and +1.0 in fixed point.
    localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;
    localparam logic signed [CW-1:0] MINUS_ONE = -ONE;

    typedef logic signed [CW-1:0] t_coord;

    // Sideband that travels with a transaction through the divider.
    typedef struct packed {
        logic   hit;
        logic   neg;
        logic   horiz;
        t_coord fixed;
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/cptrb_div.sv -----
// Pipelined unsigned restoring divider with sideband, DIV_BITS quotient bits per stage.
// Depends on cptrb_pkg.
`default_nettype none

module cptrb_div import cptrb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [2*CW-1:0]   i_num,
    input  wire logic [CW-1:0]     i_den,
    input  wire t_side             i_side,
    output logic                   o_vld,
    output logic [CW-1:0]          o_quo,
    output t_side                  o_side
);

    // Chain between stages; index 0 is the divider input.
    logic          c_vld  [0:DIV_STAGES];
    logic [CW-1:0] c_rem  [0:DIV_STAGES];
    logic [CW-1:0] c_lo   [0:DIV_STAGES];
    logic [CW-1:0] c_quo  [0:DIV_STAGES];
    logic [CW-1:0] c_den  [0:DIV_STAGES];
    t_side         c_side [0:DIV_STAGES];

    // The upper half of the numerator is below the divisor, so it seeds the remainder.
    assign c_vld[0]  = i_vld;
    assign c_rem[0]  = i_num[2*CW-1:CW];
    assign c_lo[0]   = i_num[CW-1:0];
    assign c_quo[0]  = '0;
    assign c_den[0]  = i_den;
    assign c_side[0] = i_side;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic          r_vld;
        logic [CW-1:0] r_rem, r_lo, r_quo, r_den;
        t_side         r_side;
        logic [CW-1:0] n_rem, n_lo, n_quo;

        // DIV_BITS compare-and-subtract steps per stage.
        always_comb begin
            logic [CW:0] trial;
            n_rem = c_rem[g];
            n_lo  = c_lo[g];
            n_quo = c_quo[g];
            for (int k = 0; k < DIV_BITS; k++) begin
                trial = {n_rem, n_lo[CW-1]};
                n_lo  = n_lo << 1;
                if (trial >= {1'b0, c_den[g]}) begin
                    trial = trial - {1'b0, c_den[g]};
                    n_quo = {n_quo[CW-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[CW-2:0], 1'b0};
                end
                n_rem = trial[CW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= c_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_lo   <= n_lo;
                r_quo  <= n_quo;
                r_den  <= c_den[g];
                r_side <= c_side[g];
            end
        end

        assign c_vld[g+1]  = r_vld;
        assign c_rem[g+1]  = r_rem;
        assign c_lo[g+1]   = r_lo;
        assign c_quo[g+1]  = r_quo;
        assign c_den[g+1]  = r_den;
        assign c_side[g+1] = r_side;
    end

    assign o_vld  = c_vld[DIV_STAGES];
    assign o_quo  = c_quo[DIV_STAGES];
    assign o_side = c_side[DIV_STAGES];

endmodule

`default_nettype wire

// ----- rtl/clamp_point_to_rectangle_border.sv -----
// Top level of the rectangle border clamp.
// Depends on cptrb_pkg and cptrb_div.
//
// Clamps a signed fixed-point point to the border of a configured rectangle along the
// segment from the origin. Borders are tested left, right, top, bottom; the first one
// crossed gives the result with o_was_clamped set, otherwise all outputs are zero. The
// block takes one point per cycle; each transaction passes five stages of multiply,
// compare and select, a 16-stage divider with two quotient bits a stage and the output
// register. A stalled output holds the whole pipeline. The user writes the rectangle
// registers via i_cfg_we/i_cfg_idx/i_cfg_data only while idle; the block has no check.
`default_nettype none

module clamp_point_to_rectangle_border import cptrb_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [CW-1:0] i_cfg_data,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire t_coord        i_point_x,
    input  wire t_coord        i_point_y,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic               o_was_clamped,
    output t_coord             o_clamped_x,
    output t_coord             o_clamped_y
);

    // Pipeline advances unless a finished result is held at the output.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Rectangle registers and their spans.
    t_coord r_min_x, r_min_y, r_max_x, r_max_y;
    logic signed [CW:0] r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= MINUS_ONE;
            r_min_y <= MINUS_ONE;
            r_max_x <= ONE;
            r_max_y <= ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_X: r_min_x <= i_cfg_data;
                REG_MIN_Y: r_min_y <= i_cfg_data;
                REG_MAX_X: r_max_x <= i_cfg_data;
                REG_MAX_Y: r_max_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= (CW+1)'(r_max_x) - (CW+1)'(r_min_x);
        r_dy <= (CW+1)'(r_max_y) - (CW+1)'(r_min_y);
    end

    // Stage A: input register.
    logic   r_a_vld;
    t_coord r_a_px, r_a_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_px <= i_point_x;
            r_a_py <= i_point_y;
        end
    end

    // Stage B: the six distinct products and the t range checks.
    logic   r_b_vld;
    t_coord r_b_px, r_b_py;
    logic signed [PW-1:0] r_b_py_x0, r_b_py_x1, r_b_px_y0, r_b_px_y1, r_b_d_v, r_b_d_h;
    logic [3:0] r_b_pre;
    logic [3:0] n_b_pre;

    // Parameter t = c / pa lies in [0,1] and the border is not degenerate.
    function automatic logic t_ok(input t_coord pa, input t_coord c);
        if (pa > 0) begin
            return (c >= 0) && (c <= pa);
        end else begin
            return (pa != 0) && (c <= 0) && (c >= pa);
        end
    endfunction

    always_comb begin
        n_b_pre[0] = (r_dy != 0) && t_ok(r_a_px, r_min_x);
        n_b_pre[1] = (r_dy != 0) && t_ok(r_a_px, r_max_x);
        n_b_pre[2] = (r_dx != 0) && t_ok(r_a_py, r_max_y);
        n_b_pre[3] = (r_dx != 0) && t_ok(r_a_py, r_min_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_px    <= r_a_px;
            r_b_py    <= r_a_py;
            r_b_pre   <= n_b_pre;
            r_b_py_x0 <= PW'(r_a_py) * PW'(r_min_x);
            r_b_py_x1 <= PW'(r_a_py) * PW'(r_max_x);
            r_b_px_y0 <= PW'(r_a_px) * PW'(r_min_y);
            r_b_px_y1 <= PW'(r_a_px) * PW'(r_max_y);
            r_b_d_v   <= PW'(r_a_px) * PW'(r_dy);
            r_b_d_h   <= PW'(r_a_py) * PW'(r_dx);
        end
    end

    // Stage C: numerators of s for each border.
    logic   r_c_vld;
    t_coord r_c_px, r_c_py;
    logic [3:0] r_c_pre;
    logic signed [PW:0] r_c_n [4];
    logic signed [PW-1:0] r_c_d_v, r_c_d_h;
    logic signed [PW-1:0] r_c_py_x0, r_c_py_x1, r_c_px_y0, r_c_px_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_px    <= r_b_px;
            r_c_py    <= r_b_py;
            r_c_pre   <= r_b_pre;
            r_c_n[0]  <= (PW+1)'(r_b_py_x0) - (PW+1)'(r_b_px_y0);
            r_c_n[1]  <= (PW+1)'(r_b_py_x1) - (PW+1)'(r_b_px_y0);
            r_c_n[2]  <= (PW+1)'(r_b_px_y1) - (PW+1)'(r_b_py_x0);
            r_c_n[3]  <= (PW+1)'(r_b_px_y0) - (PW+1)'(r_b_py_x0);
            r_c_d_v   <= r_b_d_v;
            r_c_d_h   <= r_b_d_h;
            r_c_py_x0 <= r_b_py_x0;
            r_c_py_x1 <= r_b_py_x1;
            r_c_px_y0 <= r_b_px_y0;
            r_c_px_y1 <= r_b_px_y1;
        end
    end

    // Stage D: s = n / d lies in [0,1], giving the hit of each border.
    logic   r_d_vld;
    t_coord r_d_px, r_d_py;
    logic [3:0] r_d_hit;
    logic [3:0] n_d_hit;
    logic signed [PW-1:0] r_d_py_x0, r_d_py_x1, r_d_px_y0, r_d_px_y1;

    function automatic logic s_ok(input logic signed [PW:0] n, input logic signed [PW-1:0] d);
        logic signed [PW:0] dw;
        dw = (PW+1)'(d);
        if (dw > 0) begin
            return (n >= 0) && (n <= dw);
        end else begin
            return (n <= 0) && (n >= dw);
        end
    endfunction

    always_comb begin
        n_d_hit[0] = r_c_pre[0] && s_ok(r_c_n[0], r_c_d_v);
        n_d_hit[1] = r_c_pre[1] && s_ok(r_c_n[1], r_c_d_v);
        n_d_hit[2] = r_c_pre[2] && s_ok(r_c_n[2], r_c_d_h);
        n_d_hit[3] = r_c_pre[3] && s_ok(r_c_n[3], r_c_d_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_px    <= r_c_px;
            r_d_py    <= r_c_py;
            r_d_hit   <= n_d_hit;
            r_d_py_x0 <= r_c_py_x0;
            r_d_py_x1 <= r_c_py_x1;
            r_d_px_y0 <= r_c_px_y0;
            r_d_px_y1 <= r_c_px_y1;
        end
    end

    // Stage E: pick the first border hit and form the divider operands.
    logic r_e_vld;
    logic [2*CW-1:0] r_e_num;
    logic [CW-1:0] r_e_den;
    t_side r_e_side;
    logic signed [PW-1:0] sel_prod;
    t_coord sel_pa;
    t_side n_e_side;
    logic signed [PW-1:0] prod_mag;

    always_comb begin
        n_e_side = '0;
        sel_prod = r_d_py_x0;
        sel_pa   = r_d_px;
        priority if (r_d_hit[0]) begin
            n_e_side.hit   = 1'b1;
            n_e_side.fixed = r_min_x;
        end else if (r_d_hit[1]) begin
            n_e_side.hit   = 1'b1;
            n_e_side.fixed = r_max_x;
            sel_prod       = r_d_py_x1;
        end else if (r_d_hit[2]) begin
            n_e_side.hit   = 1'b1;
            n_e_side.horiz = 1'b1;
            n_e_side.fixed = r_max_y;
            sel_prod       = r_d_px_y1;
            sel_pa         = r_d_py;
        end else if (r_d_hit[3]) begin
            n_e_side.hit   = 1'b1;
            n_e_side.horiz = 1'b1;
            n_e_side.fixed = r_min_y;
            sel_prod       = r_d_px_y0;
            sel_pa         = r_d_py;
        end else begin
            n_e_side.hit = 1'b0;
        end
        n_e_side.neg = (sel_prod < 0) ^ (sel_pa < 0);
        prod_mag = (sel_prod < 0) ? -sel_prod : sel_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_side <= n_e_side;
            r_e_num  <= prod_mag[2*CW-1:0];
            r_e_den  <= (sel_pa < 0) ? CW'(-sel_pa) : CW'(sel_pa);
        end
    end

    // Divide |pb * c| by |pa| to get the crossing coordinate along the border.
    logic div_vld;
    logic [CW-1:0] div_quo;
    t_side div_side;

    cptrb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_e_vld),
        .i_num   (r_e_num),
        .i_den   (r_e_den),
        .i_side  (r_e_side),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // Output register: apply the sign and place the fixed coordinate.
    logic   r_o_vld, r_o_clamped;
    t_coord r_o_x, r_o_y;
    t_coord q_signed;

    assign q_signed = div_side.neg ? -t_coord'(div_quo) : t_coord'(div_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_clamped <= div_side.hit;
            if (!div_side.hit) begin
                r_o_x <= '0;
                r_o_y <= '0;
            end else if (div_side.horiz) begin
                r_o_x <= q_signed;
                r_o_y <= div_side.fixed;
            end else begin
                r_o_x <= div_side.fixed;
                r_o_y <= q_signed;
            end
        end
    end

    assign o_valid       = r_o_vld;
    assign o_was_clamped = r_o_clamped;
    assign o_clamped_x   = r_o_x;
    assign o_clamped_y   = r_o_y;

endmodule

`default_nettype wire

// ----- rtl/cptrb_check.sv -----
// Port-level checker for the rectangle border clamp, bound to the top level.
// Depends on cptrb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cptrb_check import cptrb_pkg::*; (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_cfg_we,
    input wire logic [1:0]    i_cfg_idx,
    input wire logic [CW-1:0] i_cfg_data,
    input wire logic          i_valid,
    input wire logic          o_stall,
    input wire t_coord        i_point_x,
    input wire t_coord        i_point_y,
    input wire logic          o_valid,
    input wire logic          i_stall,
    input wire logic          o_was_clamped,
    input wire t_coord        o_clamped_x,
    input wire t_coord        o_clamped_y
);

    // Reset empties the pipeline.
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

    // A result without a crossing carries zero coordinates.
    `ASSERT_CLK(a_noclamp_zero, i_clk, i_rst_n,
        o_valid && !o_was_clamped |-> o_clamped_x == 0 && o_clamped_y == 0)

    // The input side stalls only while a result is held at the output.
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)

    // A stalled result stays put.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        o_valid && i_stall |=> o_valid && $stable(o_clamped_x) && $stable(o_clamped_y))

endmodule

bind clamp_point_to_rectangle_border cptrb_check u_check (.*);

`default_nettype wire

// ----- tb/cptrb_checker.sv -----
// Checker for the rectangle border clamp: watches both channels, predicts each result.
// Depends on cptrb_pkg.
`default_nettype none

module cptrb_checker import cptrb_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [CW-1:0] i_cfg_data,
    input  wire logic          i_valid,
    input  wire logic          i_stall_in,
    input  wire t_coord        i_point_x,
    input  wire t_coord        i_point_y,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  wire logic          i_was_clamped,
    input  wire t_coord        i_clamped_x,
    input  wire t_coord        i_clamped_y,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct {
        logic   hit;
        t_coord cx;
        t_coord cy;
    } t_crossing;

    t_coord    rect_x0, rect_y0, rect_x1, rect_y1;
    t_crossing crossings_due[$];

    // Test one border on the line a = c, running from b0 over span db along b.
    function automatic logic border_cross(input longint pa, input longint pb,
                                          input longint c, input longint b0,
                                          input longint db, output t_coord ob);
        logic signed [129:0] num, den;
        longint q;
        ob = '0;
        if (pa == 0 || db == 0) return 1'b0;
        if (pa > 0 && (c < 0 || c > pa)) return 1'b0;
        if (pa < 0 && (c > 0 || c < pa)) return 1'b0;
        num = 130'(pb) * 130'(c) - 130'(pa) * 130'(b0);
        den = 130'(pa) * 130'(db);
        if (den > 0) begin
            if (num < 0 || num > den) return 1'b0;
        end else begin
            if (num > 0 || num < den) return 1'b0;
        end
        // Signed division truncates toward zero; the magnitude fits the coordinate.
        q = (pb * c) / pa;
        ob = t_coord'(q);
        return 1'b1;
    endfunction

    function automatic t_crossing clamp_to_border(input t_coord px, input t_coord py);
        t_crossing r;
        t_coord b;
        longint x0, y0, x1, y1;
        x0 = rect_x0; y0 = rect_y0; x1 = rect_x1; y1 = rect_y1;
        r.hit = 1'b1;
        if (border_cross(px, py, x0, y0, y1 - y0, b)) begin
            r.cx = rect_x0; r.cy = b;
        end else if (border_cross(px, py, x1, y0, y1 - y0, b)) begin
            r.cx = rect_x1; r.cy = b;
        end else if (border_cross(py, px, y1, x0, x1 - x0, b)) begin
            r.cx = b; r.cy = rect_y1;
        end else if (border_cross(py, px, y0, x0, x1 - x0, b)) begin
            r.cx = b; r.cy = rect_y0;
        end else begin
            r.hit = 1'b0; r.cx = '0; r.cy = '0;
        end
        return r;
    endfunction

    assign o_pending = crossings_due.size();

    // Track registers, queue predictions, compare results.
    always @(posedge i_clk) begin
        t_crossing want;
        if (!i_rst_n) begin
            rect_x0 <= MINUS_ONE; rect_y0 <= MINUS_ONE;
            rect_x1 <= ONE;       rect_y1 <= ONE;
            o_errors = 0;
            crossings_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_X: rect_x0 <= i_cfg_data;
                    REG_MIN_Y: rect_y0 <= i_cfg_data;
                    REG_MAX_X: rect_x1 <= i_cfg_data;
                    REG_MAX_Y: rect_y1 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                crossings_due.push_back(clamp_to_border(i_point_x, i_point_y));
            if (i_out_valid && !i_out_stall) begin
                if (crossings_due.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    o_errors++;
                end else begin
                    want = crossings_due.pop_front();
                    if (i_was_clamped !== want.hit) begin
                        $error("was_clamped: expected %0d, got %0d", want.hit, i_was_clamped);
                        o_errors++;
                    end
                    if (i_clamped_x !== want.cx) begin
                        $error("clamped_x: expected %0d, got %0d", want.cx, i_clamped_x);
                        o_errors++;
                    end
                    if (i_clamped_y !== want.cy) begin
                        $error("clamped_y: expected %0d, got %0d", want.cy, i_clamped_y);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_clamp_point_to_rectangle_border.sv -----
// Testbench top for the rectangle border clamp: clock, reset, stimulus and verdict.
// Depends on cptrb_pkg, clamp_point_to_rectangle_border and cptrb_checker.
`default_nettype none

module tb_clamp_point_to_rectangle_border;
    import cptrb_pkg::*;

    localparam int LATENCY = 22;
    localparam int CYCLE_LIMIT = 400000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [1:0]    cfg_idx = REG_MIN_X;
    logic [CW-1:0] cfg_data = '0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    t_coord        px = '0;
    t_coord        py = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          was_clamped;
    t_coord        cx, cy;
    int            errors, pending;
    int            sender_idle_pct = 0;
    int            receiver_stall_pct = 0;
    int            cycles = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    clamp_point_to_rectangle_border uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .o_stall(in_stall),
        .i_point_x(px), .i_point_y(py), .o_valid(out_valid), .i_stall(out_stall),
        .o_was_clamped(was_clamped), .o_clamped_x(cx), .o_clamped_y(cy)
    );

    cptrb_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_point_x(px), .i_point_y(py), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_was_clamped(was_clamped), .i_clamped_x(cx),
        .i_clamped_y(cy), .o_errors(errors), .o_pending(pending)
    );

    // Receiver stalls at random.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one point and hold it until accepted, with random idle cycles first.
    // Valid stays high after acceptance until the next idle cycle or the next point.
    task automatic send_point(input t_coord x, input t_coord y);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        px <= x;
        py <= y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Let the pipeline empty completely.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_rect(input t_coord x0, input t_coord y0,
                              input t_coord x1, input t_coord y1);
        t_coord vals[4];
        logic [1:0] idx[4];
        vals = '{x0, y0, x1, y1};
        idx = '{REG_MIN_X, REG_MIN_Y, REG_MAX_X, REG_MAX_Y};
        for (int k = 0; k < 4; k++) begin
            cfg_we <= 1'b1;
            cfg_idx <= idx[k];
            cfg_data <= vals[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Random coordinate: mostly near the rectangle scale, sometimes full range.
    function automatic t_coord rand_coord(input int span);
        case ($urandom_range(9))
            0:       return t_coord'($urandom());
            1:       return $urandom_range(1) ? t_coord'(32'h7fffffff) : t_coord'(32'h80000000);
            2:       return '0;
            default: return t_coord'(int'($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic t_coord rand_border(input int span);
        if ($urandom_range(7) == 0) return t_coord'($urandom());
        return t_coord'(int'($urandom_range(2 * span)) - span);
    endfunction

    initial begin
        t_coord edge_vals[6];
        int span;
        edge_vals = '{t_coord'(32'h7fffffff), t_coord'(32'h80000000), '0, ONE, MINUS_ONE,
                      t_coord'(32'h00030000)};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset rectangle: axes, corners, extremes and origin.
        for (int a = 0; a < 6; a++)
            for (int b = 0; b < 4; b++)
                send_point(edge_vals[a], edge_vals[b]);
        drain();

        // Inverted and degenerate rectangles, then extreme borders.
        write_rect(ONE, ONE, MINUS_ONE, MINUS_ONE);
        send_point(t_coord'(32'h00030000), t_coord'(32'h00010000));
        send_point(t_coord'(32'hfffd0000), t_coord'(32'h00020000));
        drain();
        write_rect(ONE, MINUS_ONE, ONE, ONE);
        send_point(t_coord'(32'h00050000), t_coord'(32'h00000000));
        send_point(t_coord'(32'h00050000), t_coord'(32'h00020000));
        drain();
        write_rect(t_coord'(32'h80000000), t_coord'(32'h80000000),
                   t_coord'(32'h7fffffff), t_coord'(32'h7fffffff));
        send_point(t_coord'(32'h7fffffff), t_coord'(32'h80000000));
        send_point(t_coord'(32'h80000000), t_coord'(32'h80000000));
        drain();

        // Random phases with different idling and rectangles.
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
                default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
            endcase
            span = (ph < 12) ? (4 << 16) : 32'h3fffffff;
            write_rect(rand_border(span / 2), rand_border(span / 2),
                       rand_border(span / 2), rand_border(span / 2));
            for (int n = 0; n < 50; n++)
                send_point(rand_coord(span), rand_coord(span));
            drain();
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/cptrb_pkg.sv
rtl/cptrb_div.sv
rtl/clamp_point_to_rectangle_border.sv
rtl/cptrb_check.sv
tb/cptrb_checker.sv
tb/tb_clamp_point_to_rectangle_border.sv
